[hw/rtl/sha256_byte_stream_hasher_assert.svh]
// Assertion macros for the hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// Implication checked on every edge outside reset.
`define SBH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SBH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/sbh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_pkg
// Types, constants and round functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sbh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sbh_state_t;

    typedef struct packed {
        logic       store_byte;
        logic [7:0] store_val;
        logic       count_up;
        logic       round_start;
        logic       round_step;
        logic       chain_add;
        logic       chain_init;
        logic       len_clear;
        logic       out_load;
    } sbh_cmd_t;

    typedef struct packed {
        logic [5:0]  fill;
        logic [63:0] bit_len;
    } sbh_stat_t;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenOffset  = 56;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[hw/rtl/sbh_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_in_if / sbh_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sbh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sbh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

[hw/rtl/sbh_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_datapath
// Block store, message schedule, round unit, chaining words and length.
// ----------------------------------------------------------------------------
module sbh_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sbh_pkg::sbh_cmd_t  cmd,
    input  logic [5:0]       round_idx,
    output sbh_pkg::sbh_stat_t stat,
    output logic [31:0]      chain_out [8]
);
    import sbh_pkg::*;

    logic [511:0] blk_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];

    logic [31:0] w2, w7, w15, w16, s0, s1, wv, t1, t2;
    logic [31:0] blk_word [16];

    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            blk_word[j] = blk_reg[511 - 32*j -: 32];
        end
        w2  = w_reg[14];
        w7  = w_reg[9];
        w15 = w_reg[1];
        w16 = w_reg[0];
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        wv  = (round_idx < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
        t1  = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RoundK[round_idx] + wv;
        t2  = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // bytes shift in at the bottom; a full block has byte 0 in the top bits
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            blk_reg <= {blk_reg[503:0], cmd.store_val};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round_start)
        begin
            w_reg <= blk_word;
            v_reg <= h_reg;
        end
        else if (cmd.round_step)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= wv;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            h_reg    <= InitHash;
        end
        else
        begin
            if (cmd.count_up)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.len_clear)
            begin
                len_reg <= '0;
            end
            else if (cmd.count_up && cmd.out_load)
            begin
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.chain_init)
            begin
                h_reg <= InitHash;
            end
            else if (cmd.chain_add)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    h_reg[j] <= h_reg[j] + v_reg[j];
                end
            end
        end
    end

    assign stat.fill    = fill_reg;
    assign stat.bit_len = len_reg;
    assign chain_out    = h_reg;

endmodule

[hw/rtl/sbh_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_controller
// Sequences byte loads, padding, 64 rounds per block and digest output.
// ----------------------------------------------------------------------------
module sbh_controller (
    input  logic               clk,
    input  logic               rst_n,
    sbh_in_if.sink             in_ch,
    input  logic               out_busy,
    input  sbh_pkg::sbh_stat_t   stat,
    output sbh_pkg::sbh_cmd_t    cmd,
    output logic [5:0]         round_idx,
    output logic               emit_start
);
    import sbh_pkg::*;
    `include "sha256_byte_stream_hasher_assert.svh"

    sbh_state_t state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic       end_reg, end_next;
    logic       pad_done_reg, pad_done_next;
    logic       len_phase_reg, len_phase_next;
    logic [7:0] pad_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            end_reg       <= 1'b0;
            pad_done_reg  <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            end_reg       <= end_next;
            pad_done_reg  <= pad_done_next;
            len_phase_reg <= len_phase_next;
        end
    end

    always_comb
    begin
        case (stat.fill[2:0])
            3'd0:    pad_val = stat.bit_len[63:56];
            3'd1:    pad_val = stat.bit_len[55:48];
            3'd2:    pad_val = stat.bit_len[47:40];
            3'd3:    pad_val = stat.bit_len[39:32];
            3'd4:    pad_val = stat.bit_len[31:24];
            3'd5:    pad_val = stat.bit_len[23:16];
            3'd6:    pad_val = stat.bit_len[15:8];
            default: pad_val = stat.bit_len[7:0];
        endcase
        if (!len_phase_reg)
        begin
            pad_val = pad_done_reg ? 8'h00 : PadByte;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        end_next       = end_reg;
        pad_done_next  = pad_done_reg;
        len_phase_next = len_phase_reg;
        cmd            = '0;
        in_ch.ready    = 1'b0;
        emit_start     = 1'b0;
        round_idx      = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !out_busy;
                if (in_ch.valid && !out_busy)
                begin
                    end_next = in_ch.message_end;
                    pad_done_next = 1'b0;
                    len_phase_next = 1'b0;
                    if (in_ch.byte_present)
                    begin
                        cmd.store_byte = 1'b1;
                        cmd.store_val  = in_ch.data_byte;
                        cmd.count_up   = 1'b1;
                        cmd.out_load   = 1'b1;
                        if (stat.fill == 6'd63)
                        begin
                            state_next = ST_LOAD;
                        end
                        else if (in_ch.message_end)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (in_ch.message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.store_byte = 1'b1;
                cmd.store_val  = pad_val;
                cmd.count_up   = 1'b1;
                pad_done_next  = 1'b1;
                // last byte of a block: spill block or length block is complete
                if (stat.fill == 6'(BlockBytes - 1))
                begin
                    state_next = ST_LOAD;
                end
                else if (!len_phase_reg && stat.fill == 6'(LenOffset - 1))
                begin
                    len_phase_next = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.round_start = 1'b1;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(Rounds - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.chain_add = 1'b1;
                if (!end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_phase_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                emit_start     = 1'b1;
                cmd.chain_init = 1'b1;
                cmd.len_clear  = 1'b1;
                end_next       = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SBH_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == ST_IDLE)
    `SBH_ASSERT_NXT(a_load_rounds, clk, rst_n, state_reg == ST_LOAD, state_reg == ST_ROUND)
    `SBH_ASSERT_IMP(a_emit_end, clk, rst_n, state_reg == ST_EMIT, end_reg && len_phase_reg)

endmodule

[hw/rtl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest emitted as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one message byte per transaction (byte_present)
// and an optional message_end flag that closes the message.
// Output channel out_ch carries the eight digest words, index 0 first,
// digest_last on the eighth.
// The 64th byte of a block starts a compression: a load step, 64 rounds
// and a chaining-add step; no byte is taken until it is done.
// message_end pads one byte per cycle up to 64 bytes and runs one or two
// compressions, then the digest words leave at one per cycle while the
// receiver is ready.
// Input is held off while the digest is still being drained.
// Reset loads the initial hash and clears the length and byte count;
// a stalled receiver simply holds the current word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic      clk,
    input  logic      rst_n,
    sbh_in_if.sink    in_ch,
    sbh_out_if.source out_ch
);
    import sbh_pkg::*;
    `include "sha256_byte_stream_hasher_assert.svh"

    sbh_cmd_t    cmd;
    sbh_stat_t   stat;
    logic [5:0]  round_idx;
    logic        emit_start;
    logic [31:0] chain_out [8];
    logic [31:0] dig_reg [8];
    logic [2:0]  idx_reg;
    logic        busy_reg;

    sbh_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_busy   (busy_reg),
        .stat       (stat),
        .cmd        (cmd),
        .round_idx  (round_idx),
        .emit_start (emit_start)
    );

    sbh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .round_idx (round_idx),
        .stat      (stat),
        .chain_out (chain_out)
    );

    always_ff @(posedge clk)
    begin
        if (emit_start)
        begin
            dig_reg <= chain_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (emit_start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && out_ch.ready)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid       = busy_reg;
    assign out_ch.digest_word = dig_reg[idx_reg];
    assign out_ch.word_index  = idx_reg;
    assign out_ch.digest_last = (idx_reg == 3'd7);

    `SBH_ASSERT_IMP(a_no_in_busy, clk, rst_n, busy_reg, !in_ch.ready)
    `SBH_ASSERT_NXT(a_last_drop, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.digest_last,
        !out_ch.valid)
    `SBH_ASSERT_NXT(a_idx_step, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.digest_last,
        out_ch.valid)

endmodule
